### hw/rtl/pdcb_pkg.sv
// shared types and constants for the polyphase decimator correlator bank
package pdcb_pkg;

  localparam int TAPS_PER_PHASE_D = 16;
  localparam int CODE_LEN_D       = 32;
  localparam int NUM_CODE_WORDS_D = 4;
  localparam int SAMPLE_BITS_D    = 16;
  localparam int FRAC_BITS_D      = 15;

  localparam int FIELD_BITS = 16;
  localparam int MAX_BITS   = 15;
  localparam int ACC_BITS   = 64;

  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_EVEN_TAP = 2'd1,
    OP_ODD_TAP  = 2'd2,
    OP_CODE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIR,
    ST_FIR_SUM,
    ST_CORR,
    ST_CORR_SUM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic step;
  } lane_ctl_t;

  // floor shift and saturation to a signed sample of sb bits
  function automatic logic signed [ACC_BITS-1:0] scale_sat(
    input logic signed [ACC_BITS-1:0] v, input int fb, input int sb);
    logic signed [ACC_BITS-1:0] r;
    logic signed [ACC_BITS-1:0] hi;
    logic signed [ACC_BITS-1:0] lo;
    r  = v >>> fb;
    hi = (ACC_BITS'(1) <<< (sb - 1)) - ACC_BITS'(1);
    lo = -hi - ACC_BITS'(1);
    if (r > hi) begin
      return hi;
    end
    if (r < lo) begin
      return lo;
    end
    return r;
  endfunction

  // 64-bit saturating add
  function automatic logic signed [ACC_BITS-1:0] sat_add(
    input logic signed [ACC_BITS-1:0] a, input logic signed [ACC_BITS-1:0] b);
    logic signed [ACC_BITS-1:0] s;
    s = a + b;
    if (!a[ACC_BITS-1] && !b[ACC_BITS-1] && s[ACC_BITS-1]) begin
      return {1'b0, {(ACC_BITS-1){1'b1}}};
    end
    if (a[ACC_BITS-1] && b[ACC_BITS-1] && !s[ACC_BITS-1]) begin
      return {1'b1, {(ACC_BITS-1){1'b0}}};
    end
    return s;
  endfunction

endpackage

### hw/rtl/pdcb_if.sv
// valid/ready channel interfaces for input and result transfers
interface pdcb_in_if import pdcb_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic                          frame_first;
  logic                          frame_last;
  logic signed [FIELD_BITS-1:0]  sample_even;
  logic signed [FIELD_BITS-1:0]  sample_odd;
  logic [5:0]                    entry_index;
  logic [1:0]                    code_select;
  logic signed [FIELD_BITS-1:0]  coef_value;
  modport source (output valid, op, frame_first, frame_last, sample_even, sample_odd,
                  entry_index, code_select, coef_value, input ready);
  modport sink (input valid, op, frame_first, frame_last, sample_even, sample_odd,
                entry_index, code_select, coef_value, output ready);
endinterface

interface pdcb_out_if import pdcb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           code_index;
  logic [MAX_BITS-1:0]  max_corr;
  logic                 last_of_run;
  modport source (output valid, code_index, max_corr, last_of_run, input ready);
  modport sink (input valid, code_index, max_corr, last_of_run, output ready);
endinterface

### hw/rtl/pdcb_mac_lane.sv
// one multiply-accumulate lane: product register then saturating accumulate
module pdcb_mac_lane import pdcb_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_D
) (
  input  logic                          clk,
  input  lane_ctl_t                     ctl,
  input  logic                          prod_en,
  input  logic signed [SAMPLE_BITS-1:0] a,
  input  logic signed [FIELD_BITS-1:0]  b,
  output logic signed [ACC_BITS-1:0]    acc
);
  logic signed [SAMPLE_BITS+FIELD_BITS-1:0] prod_w;
  logic signed [ACC_BITS-1:0] prod_r;
  logic signed [ACC_BITS-1:0] acc_r;
  logic                       pv_r;

  // product at its natural width, sign-extended into the accumulator
  assign prod_w = a * b;

  always_ff @(posedge clk) begin
    prod_r <= ACC_BITS'(prod_w);
    pv_r   <= prod_en;
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= sat_add(acc_r, prod_r);
    end
  end

  assign acc = acc_r;
endmodule

### hw/rtl/pdcb_max_merge.sv
// per-code running maxima, cleared on frame start
module pdcb_max_merge import pdcb_pkg::*; #(
  parameter int NUM_CODE_WORDS = NUM_CODE_WORDS_D,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_D,
  parameter int FRAC_BITS      = FRAC_BITS_D
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic                        update,
  input  logic signed [ACC_BITS-1:0]  acc [NUM_CODE_WORDS],
  output logic [MAX_BITS-1:0]         best [NUM_CODE_WORDS]
);
  logic [MAX_BITS-1:0] best_r [NUM_CODE_WORDS];

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CODE_WORDS; c++) begin
      logic signed [ACC_BITS-1:0] y;
      y = scale_sat(acc[c], FRAC_BITS, SAMPLE_BITS);
      if (!rst_n || clear) begin
        best_r[c] <= '0;
      end else if (update && y > $signed({1'b0, best_r[c]})) begin
        best_r[c] <= (y > 64'sd32767) ? {MAX_BITS{1'b1}} : y[MAX_BITS-1:0];
      end
    end
  end

  assign best = best_r;
endmodule

### hw/rtl/polyphase_decimator_correlator_bank.sv
// top level of the polyphase decimate-by-two fir and matched-filter bank
// usage:
//  in channel: one transfer per item; op selects a sample pair or a table
//    write (even tap, odd tap, code element).
//  a sample pair runs a sequencer: a fir phase on two mac lanes (even, odd),
//    a sum state, then a correlation phase on NUM_CODE_WORDS lanes, one per
//    code, and a merge state that updates the per-code maxima
//  the cost of a pair is set by the serial walk over the taps and the
//    correlator delay line
//  on frame_last the block then emits NUM_CODE_WORDS result transfers, one
//    per cycle while out_ready is high; last_of_run marks the final code
//  the out register holds a result while the receiver stalls; in_ready is
//    low while a pair is processed and, after a frame_last pair, until the
//    last result has entered the out register
//  reset clears delay lines, maxima and control; tap and code tables hold
//    whatever was there until written
module polyphase_decimator_correlator_bank import pdcb_pkg::*; #(
  parameter int TAPS_PER_PHASE = TAPS_PER_PHASE_D,
  parameter int CODE_LEN       = CODE_LEN_D,
  parameter int NUM_CODE_WORDS = NUM_CODE_WORDS_D,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_D,
  parameter int FRAC_BITS      = FRAC_BITS_D
) (
  input  logic       clk,
  input  logic       rst_n,
  pdcb_in_if.sink    in_ch,
  pdcb_out_if.source out_ch
);
  localparam int TW = (TAPS_PER_PHASE > 1) ? $clog2(TAPS_PER_PHASE) : 1;
  localparam int KW = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam int CW = (NUM_CODE_WORDS > 1) ? $clog2(NUM_CODE_WORDS) : 1;
  localparam int SW = (CODE_LEN > TAPS_PER_PHASE ? CODE_LEN : TAPS_PER_PHASE) + 3;
  localparam int NW = $clog2(SW + 1);

  // sample storage: shift lines, read at the lane step index
  logic signed [SAMPLE_BITS-1:0] even_dl_r [TAPS_PER_PHASE];
  logic signed [SAMPLE_BITS-1:0] odd_dl_r  [TAPS_PER_PHASE];
  logic signed [SAMPLE_BITS-1:0] corr_dl_r [CODE_LEN];
  // coefficient tables; code elements live in each correlator lane
  logic signed [FIELD_BITS-1:0]  even_tap_r [TAPS_PER_PHASE];
  logic signed [FIELD_BITS-1:0]  odd_tap_r  [TAPS_PER_PHASE];

  state_t state_r, state_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] emit_r, emit_nxt;
  logic last_r;

  logic signed [SAMPLE_BITS-1:0] ev_a_r, od_a_r;
  logic signed [FIELD_BITS-1:0]  ev_b_r, od_b_r;
  logic signed [SAMPLE_BITS-1:0] cr_a_r [NUM_CODE_WORDS];
  logic fir_pen_r, cor_pen_r;

  lane_ctl_t fir_ctl, cor_ctl;
  logic signed [ACC_BITS-1:0] ev_acc, od_acc;
  logic signed [ACC_BITS-1:0] cr_acc [NUM_CODE_WORDS];
  logic [MAX_BITS-1:0] best [NUM_CODE_WORDS];
  logic signed [SAMPLE_BITS-1:0] y_dec;
  logic merge_clear, merge_upd;

  logic in_xfer;
  logic out_valid_r;
  logic [1:0] out_code_r;
  logic [MAX_BITS-1:0] out_max_r;
  logic out_last_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer = in_ch.valid && in_ch.ready;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      emit_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      emit_r  <= emit_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    emit_nxt  = emit_r;
    fir_ctl   = '0;
    cor_ctl   = '0;
    merge_upd = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && op_t'(in_ch.op) == OP_SAMPLE) begin
          state_nxt = ST_FIR;
          cnt_nxt   = '0;
          fir_ctl.clear = 1'b1;
        end
      end
      ST_FIR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == NW'(TAPS_PER_PHASE + 1)) begin
          state_nxt = ST_FIR_SUM;
        end
      end
      ST_FIR_SUM: begin
        state_nxt = ST_CORR;
        cnt_nxt   = '0;
        cor_ctl.clear = 1'b1;
      end
      ST_CORR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == NW'(CODE_LEN + 1)) begin
          state_nxt = ST_CORR_SUM;
        end
      end
      ST_CORR_SUM: begin
        merge_upd = 1'b1;
        emit_nxt  = '0;
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          emit_nxt = emit_r + 1'b1;
          if (emit_r == CW'(NUM_CODE_WORDS - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign merge_clear = in_xfer && op_t'(in_ch.op) == OP_SAMPLE && in_ch.frame_first;

  // tap table writes, item capture, shift lines
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      last_r  <= in_ch.frame_last;
      unique case (op_t'(in_ch.op))
        OP_EVEN_TAP: if (in_ch.entry_index < 7'(TAPS_PER_PHASE)) begin
          even_tap_r[in_ch.entry_index[TW-1:0]] <= in_ch.coef_value;
        end
        OP_ODD_TAP: if (in_ch.entry_index < 7'(TAPS_PER_PHASE)) begin
          odd_tap_r[in_ch.entry_index[TW-1:0]] <= in_ch.coef_value;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS_PER_PHASE; i++) begin
        even_dl_r[i] <= '0;
        odd_dl_r[i]  <= '0;
      end
      for (int k = 0; k < CODE_LEN; k++) begin
        corr_dl_r[k] <= '0;
      end
    end else begin
      if (in_xfer && op_t'(in_ch.op) == OP_SAMPLE) begin
        for (int i = TAPS_PER_PHASE - 1; i > 0; i--) begin
          even_dl_r[i] <= in_ch.frame_first ? '0 : even_dl_r[i-1];
          odd_dl_r[i]  <= in_ch.frame_first ? '0 : odd_dl_r[i-1];
        end
        even_dl_r[0] <= SAMPLE_BITS'(in_ch.sample_even);
        odd_dl_r[0]  <= in_ch.frame_first ? '0 : SAMPLE_BITS'(in_ch.sample_odd);
        if (in_ch.frame_first) begin
          for (int k = 0; k < CODE_LEN; k++) begin
            corr_dl_r[k] <= '0;
          end
        end
      end
      if (state_r == ST_FIR_SUM) begin
        for (int k = CODE_LEN - 1; k > 0; k--) begin
          corr_dl_r[k] <= corr_dl_r[k-1];
        end
        corr_dl_r[0] <= y_dec;
      end
    end
  end

  // operand fetch, one element per cycle for each lane
  always_ff @(posedge clk) begin
    fir_pen_r <= (state_r == ST_FIR) && (cnt_r < NW'(TAPS_PER_PHASE));
    cor_pen_r <= (state_r == ST_CORR) && (cnt_r < NW'(CODE_LEN));
    ev_a_r <= even_dl_r[cnt_r[TW-1:0]];
    od_a_r <= odd_dl_r[cnt_r[TW-1:0]];
    ev_b_r <= even_tap_r[cnt_r[TW-1:0]];
    od_b_r <= odd_tap_r[cnt_r[TW-1:0]];
    for (int c = 0; c < NUM_CODE_WORDS; c++) begin
      cr_a_r[c] <= corr_dl_r[KW'(CODE_LEN - 1) - cnt_r[KW-1:0]];
    end
  end

  pdcb_mac_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_even (
    .clk(clk), .ctl(fir_ctl), .prod_en(fir_pen_r), .a(ev_a_r), .b(ev_b_r), .acc(ev_acc));
  pdcb_mac_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_odd (
    .clk(clk), .ctl(fir_ctl), .prod_en(fir_pen_r), .a(od_a_r), .b(od_b_r), .acc(od_acc));

  // odd and even partial sums combine here, then the decimated sample is scaled
  logic signed [ACC_BITS-1:0] fir_sum;
  logic signed [ACC_BITS-1:0] fir_y;
  assign fir_sum = sat_add(ev_acc, od_acc);
  assign fir_y   = scale_sat(fir_sum, FRAC_BITS, SAMPLE_BITS);
  assign y_dec   = fir_y[SAMPLE_BITS-1:0];

  // one lane per code, each with its own code element store and registered read
  for (genvar c = 0; c < NUM_CODE_WORDS; c++) begin : g_corr
    logic signed [FIELD_BITS-1:0] code_mem [CODE_LEN];
    logic signed [FIELD_BITS-1:0] code_b_r;

    always_ff @(posedge clk) begin
      if (in_xfer && op_t'(in_ch.op) == OP_CODE &&
          int'(in_ch.entry_index) < CODE_LEN && int'(in_ch.code_select) == c) begin
        code_mem[in_ch.entry_index[KW-1:0]] <= in_ch.coef_value;
      end
      code_b_r <= code_mem[cnt_r[KW-1:0]];
    end

    pdcb_mac_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
      .clk(clk), .ctl(cor_ctl), .prod_en(cor_pen_r), .a(cr_a_r[c]), .b(code_b_r),
      .acc(cr_acc[c]));
  end

  pdcb_max_merge #(.NUM_CODE_WORDS(NUM_CODE_WORDS), .SAMPLE_BITS(SAMPLE_BITS),
                   .FRAC_BITS(FRAC_BITS)) u_merge (
    .clk(clk), .rst_n(rst_n), .clear(merge_clear), .update(merge_upd),
    .acc(cr_acc), .best(best));

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
      out_code_r  <= 2'(emit_r);
      out_max_r   <= best[emit_r];
      out_last_r  <= (emit_r == CW'(NUM_CODE_WORDS - 1));
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.code_index  = out_code_r;
  assign out_ch.max_corr    = out_max_r;
  assign out_ch.last_of_run = out_last_r;

  // no new item while results are pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready);
  // a stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_max_r)))
    else $error("result changed under stall");
  // emission only follows a frame-last pair
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> last_r) else $error("emit without frame_last");
endmodule

### verif/pdcb_tb_pkg.sv
// shared constants for the polyphase decimator correlator bank testbench
package pdcb_tb_pkg;
  localparam int TAPS  = 16;
  localparam int CLEN  = 32;
  localparam int NCODE = 4;
endpackage

### verif/pdcb_tb_checker.sv
// checker: predicts per-code maxima from observed input transfers and compares results
module pdcb_tb_checker import pdcb_pkg::*; import pdcb_tb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  pdcb_in_if         in_ch,
  pdcb_out_if        out_ch,
  output int         fail_count,
  output int         pending_maxima
);
  typedef struct packed {
    logic [1:0]          code_index;
    logic [MAX_BITS-1:0] max_corr;
    logic                last_of_run;
  } max_res_t;

  max_res_t maxima_q[$];
  longint even_line[TAPS];
  longint odd_line[TAPS];
  longint even_coef[TAPS];
  longint odd_coef[TAPS];
  longint code_rom[NCODE][CLEN];
  longint decim_line[CLEN];
  longint peak[NCODE];

  function automatic longint floor_clamp(longint v);
    longint r;
    r = v >>> FRAC_BITS_D;
    if (r > 32767) return 32767;
    if (r < -32768) return -32768;
    return r;
  endfunction

  task automatic predict_pair(logic first, logic last, longint se, longint so);
    longint acc;
    longint y;
    max_res_t r;
    if (first) begin
      foreach (even_line[i]) begin
        even_line[i] = 0;
        odd_line[i] = 0;
      end
      foreach (decim_line[k]) decim_line[k] = 0;
      foreach (peak[c]) peak[c] = 0;
    end
    for (int i = TAPS - 1; i > 0; i--) begin
      even_line[i] = even_line[i-1];
      odd_line[i] = odd_line[i-1];
    end
    even_line[0] = se;
    odd_line[0] = first ? 0 : so;
    acc = 0;
    for (int i = 0; i < TAPS; i++) begin
      acc += even_line[i] * even_coef[i] + odd_line[i] * odd_coef[i];
    end
    y = floor_clamp(acc);
    for (int k = CLEN - 1; k > 0; k--) decim_line[k] = decim_line[k-1];
    decim_line[0] = y;
    for (int c = 0; c < NCODE; c++) begin
      acc = 0;
      for (int k = 0; k < CLEN; k++) acc += decim_line[CLEN-1-k] * code_rom[c][k];
      y = floor_clamp(acc);
      if (y > peak[c]) peak[c] = y;
    end
    if (last) begin
      for (int c = 0; c < NCODE; c++) begin
        r.code_index = c[1:0];
        r.max_corr = peak[c][MAX_BITS-1:0];
        r.last_of_run = (c == NCODE - 1);
        maxima_q.push_back(r);
      end
    end
  endtask

  initial begin
    foreach (even_line[i]) begin
      even_line[i] = 0;
      odd_line[i] = 0;
      even_coef[i] = 0;
      odd_coef[i] = 0;
    end
    foreach (code_rom[c, k]) code_rom[c][k] = 0;
    foreach (decim_line[k]) decim_line[k] = 0;
    foreach (peak[c]) peak[c] = 0;
  end

  always @(posedge clk) begin
    max_res_t want;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      case (op_t'(in_ch.op))
        OP_EVEN_TAP: if (in_ch.entry_index < TAPS) even_coef[in_ch.entry_index] = in_ch.coef_value;
        OP_ODD_TAP:  if (in_ch.entry_index < TAPS) odd_coef[in_ch.entry_index] = in_ch.coef_value;
        OP_CODE: if (in_ch.entry_index < CLEN)
          code_rom[in_ch.code_select][in_ch.entry_index] = in_ch.coef_value;
        default: predict_pair(in_ch.frame_first, in_ch.frame_last,
                              in_ch.sample_even, in_ch.sample_odd);
      endcase
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (maxima_q.size() == 0) begin
        $display("%0t: unexpected result code %0d max %0d", $time,
                 out_ch.code_index, out_ch.max_corr);
        fail_count++;
      end else begin
        want = maxima_q.pop_front();
        if (want.code_index !== out_ch.code_index || want.max_corr !== out_ch.max_corr ||
            want.last_of_run !== out_ch.last_of_run) begin
          $display("%0t: mismatch expected code %0d max %0d last %0b, got %0d %0d %0b",
                   $time, want.code_index, want.max_corr, want.last_of_run,
                   out_ch.code_index, out_ch.max_corr, out_ch.last_of_run);
          fail_count++;
        end
      end
    end
    pending_maxima = maxima_q.size();
  end
endmodule

### verif/polyphase_decimator_correlator_bank_tb.sv
// top of the testbench: clock, reset, stimulus and verdict for the correlator bank
module polyphase_decimator_correlator_bank_tb;
  import pdcb_pkg::*;
  import pdcb_tb_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_maxima;
  int   cycle_count;
  bit   hold_off;

  pdcb_in_if  in_ch ();
  pdcb_out_if out_ch ();

  polyphase_decimator_correlator_bank u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  pdcb_tb_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .fail_count     (fail_count),
    .pending_maxima (pending_maxima)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit: ~210 items, pair processing plus stalls, taken many times over
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("polyphase_decimator_correlator_bank_tb NOT OK");
        $finish;
      end
    end
  end

  // short random gaps, rarely long
  function automatic int idle_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // table value: mostly random, sometimes full scale
  function automatic logic [15:0] pick_coef();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'h7fff;
    if (r == 1) return 16'h8000;
    return 16'($urandom);
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? idle_gap() : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // one transfer on the input channel
  task automatic send(op_t op, bit first, bit last, logic [15:0] se, logic [15:0] so,
                      logic [5:0] idx, logic [1:0] sel, logic [15:0] coef);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.frame_first <= first;
    in_ch.frame_last  <= last;
    in_ch.sample_even <= se;
    in_ch.sample_odd  <= so;
    in_ch.entry_index <= idx;
    in_ch.code_select <= sel;
    in_ch.coef_value  <= coef;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // every tap and code element once, with random frame flags and samples
  task automatic load_tables();
    for (int i = 0; i < TAPS; i++) begin
      send(OP_EVEN_TAP, 1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
           6'(i), 2'($urandom), pick_coef());
      send(OP_ODD_TAP, 1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
           6'(i), 2'($urandom), pick_coef());
    end
    for (int c = 0; c < NCODE; c++) begin
      for (int k = 0; k < CLEN; k++) begin
        send(OP_CODE, 1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
             6'(k), 2'(c), pick_coef());
      end
    end
  endtask

  // overwrite one in-range table entry
  task automatic rewrite_entry();
    op_t op;
    op = op_t'($urandom_range(1, 3));
    if (op == OP_CODE) begin
      send(op, 1'b0, 1'b0, 16'h0, 16'h0, 6'($urandom_range(0, CLEN - 1)),
           2'($urandom), pick_coef());
    end else begin
      send(op, 1'b0, 1'b0, 16'h0, 16'h0, 6'($urandom_range(0, TAPS - 1)),
           2'($urandom), pick_coef());
    end
  endtask

  initial begin
    logic [15:0] se;
    logic [15:0] so;
    int flen;
    hold_off = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_SAMPLE;
    in_ch.frame_first = 1'b0;
    in_ch.frame_last = 1'b0;
    in_ch.sample_even = '0;
    in_ch.sample_odd = '0;
    in_ch.entry_index = '0;
    in_ch.code_select = '0;
    in_ch.coef_value = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // every table entry written before any pair reads it
    load_tables();
    // extremes: saturating samples
    send(OP_SAMPLE, 1'b1, 1'b0, 16'h7fff, 16'h8000, 6'd0, 2'd0, 16'h0);
    send(OP_SAMPLE, 1'b0, 1'b0, 16'h8000, 16'h7fff, 6'd0, 2'd0, 16'h0);
    send(OP_SAMPLE, 1'b0, 1'b1, 16'h7fff, 16'h7fff, 6'd0, 2'd0, 16'h0);
    send(OP_SAMPLE, 1'b1, 1'b1, 16'h8000, 16'h8000, 6'd0, 2'd0, 16'h0);
    // out-of-range table writes are dropped
    send(OP_EVEN_TAP, 1'b0, 1'b1, 16'h0, 16'h0, 6'd63, 2'd0, 16'h1234);
    send(OP_ODD_TAP, 1'b1, 1'b0, 16'h0, 16'h0, 6'd16, 2'd0, 16'h4321);
    send(OP_CODE, 1'b1, 1'b1, 16'h0, 16'h0, 6'd32, 2'd3, 16'h5555);

    // long receiver stall while frames keep coming
    hold_off = 1;
    for (int f = 0; f < 3; f++) begin
      send(OP_SAMPLE, 1'b1, 1'b1, 16'($urandom), 16'($urandom), 6'd0, 2'd0, 16'h0);
    end

    // random frames, with occasional table updates between frames and out-of-range writes inside them
    for (int n = 0; n < 36; n += flen) begin
      flen = $urandom_range(1, 8);
      if ($urandom_range(0, 3) == 0) rewrite_entry();
      for (int j = 0; j < flen; j++) begin
        se = 16'($urandom);
        so = 16'($urandom);
        if ($urandom_range(0, 5) == 0) se = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        if ($urandom_range(0, 15) == 0)
          send(op_t'($urandom_range(1, 3)), 1'($urandom), 1'($urandom), se, so,
               6'($urandom_range(32, 63)), 2'($urandom), 16'($urandom));
        send(OP_SAMPLE, j == 0, j == flen - 1, se, so, 6'd0, 2'd0, 16'h0);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_maxima != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("polyphase_decimator_correlator_bank_tb OK");
    end else begin
      $display("polyphase_decimator_correlator_bank_tb NOT OK");
    end
    $finish;
  end
endmodule
